### rtl/shortest_arc_quaternion_macros.svh
// assertion macros for the shortest-arc quaternion checker
`ifndef SHORTEST_ARC_QUATERNION_MACROS_SVH
`define SHORTEST_ARC_QUATERNION_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SAQ_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAQ_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

### rtl/saq_pkg.sv
// shared types and constants for the shortest-arc quaternion block
package saq_pkg;

    localparam int unsigned ONE_Q14   = 16384;
    localparam int unsigned SQ_STEPS  = 16;
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned LANES     = 3;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [32:0] ax;
        logic signed [32:0] ay;
        logic signed [32:0] az;
        logic signed [15:0] dq;
        logic [16:0]        t;
    } saq_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } saq_qstat_t;

endpackage

### rtl/saq_front.sv
// front end: cross and dot products, dot rounding and clamping
module saq_front
    import saq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [15:0] from_x,
    input  logic signed [15:0] from_y,
    input  logic signed [15:0] from_z,
    input  logic signed [15:0] to_x,
    input  logic signed [15:0] to_y,
    input  logic signed [15:0] to_z,
    output logic               out_valid,
    output saq_item_t          out_item
);

    logic               p_valid_reg;
    logic signed [31:0] p_reg [0:8];
    logic               i_valid_reg;
    saq_item_t          item_reg;
    saq_item_t          item_next;

    logic signed [33:0] dot;
    logic [33:0]        dmag;
    logic [33:0]        dround;
    logic [15:0]        dsat;
    logic signed [15:0] dq;
    logic [15:0]        tbase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            i_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg[0] <= from_y * to_z;
        p_reg[1] <= from_z * to_y;
        p_reg[2] <= from_z * to_x;
        p_reg[3] <= from_x * to_z;
        p_reg[4] <= from_x * to_y;
        p_reg[5] <= from_y * to_x;
        p_reg[6] <= from_x * to_x;
        p_reg[7] <= from_y * to_y;
        p_reg[8] <= from_z * to_z;
        item_reg <= item_next;
    end

    always_comb
    begin
        dot    = 34'(p_reg[6]) + 34'(p_reg[7]) + 34'(p_reg[8]);
        dmag   = dot[33] ? 34'(-dot) : 34'(dot);
        // round half away from zero, then clamp to one
        dround = (dmag + 34'd8192) >> 14;
        dsat   = (dround > 34'(ONE_Q14)) ? 16'(ONE_Q14) : dround[15:0];
        dq     = dot[33] ? 16'(-$signed(dsat)) : $signed(dsat);
        tbase  = 16'(dq + 16'sd16384);
        item_next.ax = 33'(p_reg[0]) - 33'(p_reg[1]);
        item_next.ay = 33'(p_reg[2]) - 33'(p_reg[3]);
        item_next.az = 33'(p_reg[4]) - 33'(p_reg[5]);
        item_next.dq = dq;
        item_next.t  = {tbase, 1'b0};
    end

    assign out_valid = i_valid_reg;
    assign out_item  = item_reg;

endmodule

### rtl/saq_queue.sv
// two-entry queue between front and back
module saq_queue
    import saq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  saq_item_t  push_item,
    input  logic       pop,
    output saq_item_t  head,
    output saq_qstat_t stat
);

    saq_item_t  mem [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/saq_back.sv
// back end: pipelined square root and three pipelined rounding dividers
module saq_back
    import saq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  saq_item_t          in_item,
    output logic               done,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic [14:0]        quat_w,
    output logic signed [15:0] dot_clamped,
    output logic               opposite_flag
);

    // square root pipeline, one result bit per stage
    logic        sq_valid_reg [0:SQ_STEPS-1];
    saq_item_t   sq_item_reg  [0:SQ_STEPS-1];
    logic [31:0] sq_rad_reg   [0:SQ_STEPS-1];
    logic [17:0] sq_rem_reg   [0:SQ_STEPS-1];
    logic [15:0] sq_root_reg  [0:SQ_STEPS-1];
    logic [31:0] sq_rad_next  [0:SQ_STEPS-1];
    logic [17:0] sq_rem_next  [0:SQ_STEPS-1];
    logic [15:0] sq_root_next [0:SQ_STEPS-1];

    // divider pipeline, index 0 is the setup stage
    logic               dv_valid_reg [0:DIV_STEPS];
    logic               dv_opp_reg   [0:DIV_STEPS];
    logic signed [15:0] dv_dq_reg    [0:DIV_STEPS];
    logic [15:0]        dv_s_reg     [0:DIV_STEPS];
    logic [LANES-1:0]   dv_neg_reg   [0:DIV_STEPS];
    logic [LANES-1:0]   dv_sat_reg   [0:DIV_STEPS];
    logic [LANES-1:0][15:0] dv_rem_reg [0:DIV_STEPS];
    logic [LANES-1:0][15:0] dv_nq_reg  [0:DIV_STEPS];
    logic [LANES-1:0][15:0] dv_rem_next [1:DIV_STEPS];
    logic [LANES-1:0][15:0] dv_nq_next  [1:DIV_STEPS];

    logic                   set_opp;
    logic [15:0]            set_s;
    logic [LANES-1:0]       set_neg;
    logic [LANES-1:0]       set_sat;
    logic [LANES-1:0][15:0] set_rem;
    logic [LANES-1:0][15:0] set_nq;
    logic signed [32:0]     lane_a [0:LANES-1];
    logic [33:0]            lane_n [0:LANES-1];
    logic [32:0]            lane_mag [0:LANES-1];

    logic                   done_reg;
    logic signed [15:0]     q_reg [0:LANES-1];
    logic signed [15:0]     q_next [0:LANES-1];
    logic [14:0]            w_reg;
    logic [16:0]            w_sum;
    logic signed [15:0]     dq_reg;
    logic                   opp_reg;

    always_comb
    begin
        for (int j = 0; j < SQ_STEPS; j++)
        begin
            logic [31:0] rad;
            logic [17:0] rem;
            logic [15:0] root;
            logic [19:0] r2;
            logic [19:0] trial;
            if (j == 0)
            begin
                rad  = {1'b0, in_item.t, 14'b0};
                rem  = 18'd0;
                root = 16'd0;
            end
            else
            begin
                rad  = sq_rad_reg[j-1];
                rem  = sq_rem_reg[j-1];
                root = sq_root_reg[j-1];
            end
            r2    = {rem, rad[31:30]};
            trial = {2'b00, root, 2'b01};
            sq_rad_next[j] = {rad[29:0], 2'b00};
            if (r2 >= trial)
            begin
                sq_rem_next[j]  = 18'(r2 - trial);
                sq_root_next[j] = {root[14:0], 1'b1};
            end
            else
            begin
                sq_rem_next[j]  = r2[17:0];
                sq_root_next[j] = {root[14:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        set_opp = (sq_item_reg[SQ_STEPS-1].t == 17'd0);
        // opposite vectors: dividing by one in Q1.14 gives the plain rounding
        set_s   = set_opp ? 16'(ONE_Q14) : sq_root_reg[SQ_STEPS-1];
        lane_a[0] = sq_item_reg[SQ_STEPS-1].ax;
        lane_a[1] = sq_item_reg[SQ_STEPS-1].ay;
        lane_a[2] = sq_item_reg[SQ_STEPS-1].az;
        for (int l = 0; l < LANES; l++)
        begin
            set_neg[l]  = lane_a[l][32];
            lane_mag[l] = lane_a[l][32] ? 33'(-lane_a[l]) : 33'(lane_a[l]);
            lane_n[l]   = 34'(lane_mag[l]) + 34'(set_s >> 1);
            set_sat[l]  = (lane_n[l] >= {2'b00, set_s, 16'b0});
            set_rem[l]  = lane_n[l][31:16];
            set_nq[l]   = lane_n[l][15:0];
        end
    end

    always_comb
    begin
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                logic [16:0] r;
                r = {dv_rem_reg[j-1][l], dv_nq_reg[j-1][l][15]};
                if (r >= {1'b0, dv_s_reg[j-1]})
                begin
                    dv_rem_next[j][l] = 16'(r - {1'b0, dv_s_reg[j-1]});
                    dv_nq_next[j][l]  = {dv_nq_reg[j-1][l][14:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[j][l] = r[15:0];
                    dv_nq_next[j][l]  = {dv_nq_reg[j-1][l][14:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [15:0] mag;
            if (dv_sat_reg[DIV_STEPS][l] || (dv_nq_reg[DIV_STEPS][l] > 16'(ONE_Q14)))
                mag = 16'(ONE_Q14);
            else
                mag = dv_nq_reg[DIV_STEPS][l];
            q_next[l] = dv_neg_reg[DIV_STEPS][l] ? 16'(-$signed(mag)) : $signed(mag);
        end
        w_sum = 17'(dv_s_reg[DIV_STEPS]) + 17'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SQ_STEPS; j++)
                sq_valid_reg[j] <= 1'b0;
            for (int j = 0; j <= DIV_STEPS; j++)
                dv_valid_reg[j] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            sq_valid_reg[0] <= in_valid;
            for (int j = 1; j < SQ_STEPS; j++)
                sq_valid_reg[j] <= sq_valid_reg[j-1];
            dv_valid_reg[0] <= sq_valid_reg[SQ_STEPS-1];
            for (int j = 1; j <= DIV_STEPS; j++)
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            done_reg <= dv_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < SQ_STEPS; j++)
        begin
            sq_item_reg[j] <= (j == 0) ? in_item : sq_item_reg[j-1];
            sq_rad_reg[j]  <= sq_rad_next[j];
            sq_rem_reg[j]  <= sq_rem_next[j];
            sq_root_reg[j] <= sq_root_next[j];
        end
        dv_opp_reg[0] <= set_opp;
        dv_dq_reg[0]  <= sq_item_reg[SQ_STEPS-1].dq;
        dv_s_reg[0]   <= set_s;
        dv_neg_reg[0] <= set_neg;
        dv_sat_reg[0] <= set_sat;
        dv_rem_reg[0] <= set_rem;
        dv_nq_reg[0]  <= set_nq;
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            dv_opp_reg[j] <= dv_opp_reg[j-1];
            dv_dq_reg[j]  <= dv_dq_reg[j-1];
            dv_s_reg[j]   <= dv_s_reg[j-1];
            dv_neg_reg[j] <= dv_neg_reg[j-1];
            dv_sat_reg[j] <= dv_sat_reg[j-1];
            dv_rem_reg[j] <= dv_rem_next[j];
            dv_nq_reg[j]  <= dv_nq_next[j];
        end
        for (int l = 0; l < LANES; l++)
            q_reg[l] <= q_next[l];
        w_reg   <= dv_opp_reg[DIV_STEPS] ? 15'd0 : w_sum[15:1];
        dq_reg  <= dv_dq_reg[DIV_STEPS];
        opp_reg <= dv_opp_reg[DIV_STEPS];
    end

    assign done          = done_reg;
    assign quat_x        = q_reg[0];
    assign quat_y        = q_reg[1];
    assign quat_z        = q_reg[2];
    assign quat_w        = w_reg;
    assign dot_clamped   = dq_reg;
    assign opposite_flag = opp_reg;

endmodule

### rtl/shortest_arc_quaternion.sv
// Shortest-arc rotation quaternion between two unit vectors, Q1.14 fixed point.
// Input: drive from_* and to_* with start high; a transfer happens at a rising
// edge where start is high and busy is low. busy reflects a full internal queue.
// Output: done is high for one cycle with quat_x/y/z/w, dot_clamped and
// opposite_flag; that cycle is the result transfer, the receiver cannot stall.
// Pipeline: front-end products and item registers, the queue, a 16-stage square
// root, a 16-stage rounding divider and the output registers.
// Throughput: one item per cycle; every stage advances each cycle, so the queue
// between front and back never holds more than one item and busy stays low.
// quat_w is s/2 rounded half up; vector part is cross/s rounded and saturated to +-1.0.
// Opposite vectors (clamped dot of -1.0) give the cross product itself with
// quat_w zero and opposite_flag set.
// Reset (rst_n low, asynchronous) empties the pipeline and queue; no result is
// presented until a new item is transferred.
module shortest_arc_quaternion
    import saq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] from_x,
    input  logic signed [15:0] from_y,
    input  logic signed [15:0] from_z,
    input  logic signed [15:0] to_x,
    input  logic signed [15:0] to_y,
    input  logic signed [15:0] to_z,
    output logic               done,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic [14:0]        quat_w,
    output logic signed [15:0] dot_clamped,
    output logic               opposite_flag
);

    logic       f_valid;
    saq_item_t  f_item;
    saq_item_t  q_head;
    saq_qstat_t q_stat;

    assign busy = q_stat.full;

    saq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .from_x    (from_x),
        .from_y    (from_y),
        .from_z    (from_z),
        .to_x      (to_x),
        .to_y      (to_y),
        .to_z      (to_z),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    saq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_item (f_item),
        .pop       (1'b1),
        .head      (q_head),
        .stat      (q_stat)
    );

    saq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (!q_stat.empty),
        .in_item       (q_head),
        .done          (done),
        .quat_x        (quat_x),
        .quat_y        (quat_y),
        .quat_z        (quat_z),
        .quat_w        (quat_w),
        .dot_clamped   (dot_clamped),
        .opposite_flag (opposite_flag)
    );

endmodule

### rtl/saq_checker.sv
// port-level checker for the shortest-arc quaternion block, with its bind
`include "shortest_arc_quaternion_macros.svh"

module saq_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] quat_x,
    input logic [14:0]        quat_w,
    input logic signed [15:0] dot_clamped,
    input logic               opposite_flag
);

    `SAQ_ASSERT_IMP(a_opp_w_zero, done && opposite_flag, quat_w == 15'd0, "opposite w nonzero")
    `SAQ_ASSERT_IMP(a_opp_dot, done && opposite_flag, dot_clamped == -16'sd16384, "opposite dot")
    `SAQ_ASSERT_IMP(a_w_range, done, quat_w <= 15'd16384, "quat_w above one")
    `SAQ_ASSERT_IMP(a_x_rng, done, (quat_x >= -16'sd16384) && (quat_x <= 16'sd16384), "x range")
    `SAQ_ASSERT_NXT(a_no_busy, 1'b1, !busy, "queue filled up")

endmodule

bind shortest_arc_quaternion saq_checker u_saq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .done          (done),
    .quat_x        (quat_x),
    .quat_w        (quat_w),
    .dot_clamped   (dot_clamped),
    .opposite_flag (opposite_flag)
);

### verif/shortest_arc_quaternion_test.sv
// self-checking testbench for the shortest-arc quaternion block
`timescale 1ns / 1ps

module shortest_arc_quaternion_test;
    import saq_pkg::*;

    typedef struct {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic [14:0]        qw;
        logic signed [15:0] dq;
        logic               opp;
    } quat_res_t;

    typedef struct {
        logic signed [15:0] v [6];
        bit                 typed;
        quat_res_t          res;
    } vec_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] from_x, from_y, from_z, to_x, to_y, to_z;
    logic               done;
    logic signed [15:0] quat_x, quat_y, quat_z;
    logic [14:0]        quat_w;
    logic signed [15:0] dot_clamped;
    logic               opposite_flag;

    quat_res_t pending_quats [$];
    int        mismatches;
    bit        tx_idle_ok;
    vec_row_t  arc_rows [$];

    shortest_arc_quaternion i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .from_x(from_x), .from_y(from_y), .from_z(from_z),
        .to_x(to_x), .to_y(to_y), .to_z(to_z),
        .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .quat_w(quat_w), .dot_clamped(dot_clamped), .opposite_flag(opposite_flag)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clip_q14(longint v);
        longint one;
        one = ONE_Q14;
        if (v > one)
            return one;
        if (v < -one)
            return -one;
        return v;
    endfunction

    // start from a real estimate, then step to the exact floor
    function automatic longint floor_sqrt(longint v);
        longint r;
        r = longint'($sqrt(real'(v)));
        while (r * r > v)
            r = r - 1;
        while ((r + 1) * (r + 1) <= v)
            r = r + 1;
        return r;
    endfunction

    function automatic quat_res_t arc_quat(logic signed [15:0] v [6]);
        quat_res_t r;
        longint fx, fy, fz, tx, ty, tz, ax, ay, az, dot, dq, t, s;
        fx = v[0]; fy = v[1]; fz = v[2];
        tx = v[3]; ty = v[4]; tz = v[5];
        ax = fy * tz - fz * ty;
        ay = fz * tx - fx * tz;
        az = fx * ty - fy * tx;
        dot = fx * tx + fy * ty + fz * tz;
        dq = clip_q14(round_div(dot, ONE_Q14));
        t = 2 * (dq + ONE_Q14);
        r.dq = dq[15:0];
        if (t == 0)
        begin
            s = ONE_Q14;
            r.qw = '0;
            r.opp = 1'b1;
        end
        else
        begin
            s = floor_sqrt(t * 16384);
            r.qw = 15'((s + 1) >>> 1);
            r.opp = 1'b0;
        end
        r.qx = 16'(clip_q14(round_div(ax, s)));
        r.qy = 16'(clip_q14(round_div(ay, s)));
        r.qz = 16'(clip_q14(round_div(az, s)));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        quat_res_t e;
        if (rst_n && done)
        begin
            if (pending_quats.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                e = pending_quats.pop_front();
                if (quat_x !== e.qx) report_mismatch("quat_x", quat_x, e.qx);
                if (quat_y !== e.qy) report_mismatch("quat_y", quat_y, e.qy);
                if (quat_z !== e.qz) report_mismatch("quat_z", quat_z, e.qz);
                if (quat_w !== e.qw) report_mismatch("quat_w", quat_w, e.qw);
                if (dot_clamped !== e.dq)
                    report_mismatch("dot_clamped", dot_clamped, e.dq);
                if (opposite_flag !== e.opp)
                    report_mismatch("opposite_flag", opposite_flag, e.opp);
            end
        end
    end

    function automatic logic signed [15:0] rnd_comp(int mode);
        int unsigned r;
        case (mode)
            0: r = $urandom_range(0, 32768);
            1: r = $urandom();
            default: r = $urandom_range(0, 8);
        endcase
        if (mode == 0)
            return 16'(int'(r) - 16384);
        if (mode == 1)
            return r[15:0];
        return 16'(int'(r) - 4);
    endfunction

    task automatic add_row(int a, int b, int c, int d, int e, int f, bit typed,
                           int qx, int qy, int qz, int qw, int dq, int opp);
        vec_row_t row;
        row.v[0] = a; row.v[1] = b; row.v[2] = c;
        row.v[3] = d; row.v[4] = e; row.v[5] = f;
        row.typed = typed;
        row.res.qx = qx; row.res.qy = qy; row.res.qz = qz;
        row.res.qw = qw; row.res.dq = dq; row.res.opp = opp;
        arc_rows.push_back(row);
    endtask

    // one transfer per call, sometimes with a random idle gap before it
    task automatic send_pair(logic signed [15:0] v [6], quat_res_t want);
        int gap;
        if (tx_idle_ok && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        from_x <= v[0]; from_y <= v[1]; from_z <= v[2];
        to_x <= v[3]; to_y <= v[4]; to_z <= v[5];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_quats.push_back(want);
    endtask

    initial
    begin
        #2000000;
        $display("FAIL shortest_arc_quaternion");
        $finish;
    end

    initial
    begin
        logic signed [15:0] v [6];
        quat_res_t want;
        int mode;
        int k;
        mismatches = 0;
        tx_idle_ok = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        from_x = '0; from_y = '0; from_z = '0;
        to_x = '0; to_y = '0; to_z = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // typed: parallel unit x, zero vectors, opposite x, opposite y
        add_row(16384, 0, 0, 16384, 0, 0, 1, 0, 0, 0, 16384, 16384, 0);
        add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 11585, 0, 0);
        add_row(16384, 0, 0, -16384, 0, 0, 1, 0, 0, 0, 0, -16384, 1);
        add_row(0, 16384, 0, 0, -16384, 0, 1, 0, 0, 0, 0, -16384, 1);
        add_row(16384, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 16384, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0);
        add_row(-16384, -16384, -16384, -16384, -16384, -16384, 0, 0, 0, 0, 0, 0, 0);
        add_row(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 0);
        add_row(32767, -32768, 32767, -32768, 32767, -32768, 0, 0, 0, 0, 0, 0, 0);
        add_row(32767, 0, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(-32768, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(16384, 100, 0, -16384, 0, 100, 0, 0, 0, 0, 0, 0, 0);
        add_row(11585, 11585, 0, -11585, -11585, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 8192, 0, 0, 0, 0, 0, 0, 0);
        add_row(8192, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(16384, 16384, 0, -16384, 16384, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0);
        foreach (arc_rows[i])
        begin
            v = arc_rows[i].v;
            want = arc_rows[i].typed ? arc_rows[i].res : arc_quat(v);
            send_pair(v, want);
        end

        for (k = 0; k < 550; k++)
        begin
            if (k > 450)
                tx_idle_ok = 1'b0;
            mode = $urandom_range(0, 9);
            for (int j = 0; j < 6; j++)
                v[j] = rnd_comp(mode < 6 ? 0 : (mode < 8 ? 1 : 2));
            // near-opposite pairs of small components, whose clamped dot rounds to zero
            if (mode == 9)
                for (int j = 0; j < 3; j++)
                    v[j + 3] = -v[j] + 16'(int'($urandom_range(0, 2)) - 1);
            send_pair(v, arc_quat(v));
        end
        start <= 1'b0;

        while (pending_quats.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("PASS shortest_arc_quaternion");
        else
            $display("FAIL shortest_arc_quaternion");
        $finish;
    end

endmodule

### shortest_arc_quaternion.f
+incdir+rtl
rtl/saq_pkg.sv
rtl/saq_front.sv
rtl/saq_queue.sv
rtl/saq_back.sv
rtl/shortest_arc_quaternion.sv
rtl/saq_checker.sv
verif/shortest_arc_quaternion_test.sv
